>>> design/b62_pkg.sv
package b62_pkg;

    localparam int POS_W    = 5;
    localparam int WORD_W   = 30;
    localparam int VAL_W    = 6;
    localparam int MASK_W   = 15;
    localparam int GROUPS   = 3;
    localparam int GRP_LEN  = 5;
    localparam int ASCII_W  = 7;
    localparam int CHAR_W   = 8;
    localparam int STAT_W   = 2;
    localparam int OUT_W    = 120;

    localparam logic [POS_W-1:0] BODY_LEN = 5'd15;
    localparam logic [POS_W-1:0] FULL_LEN = 5'd18;
    localparam logic [POS_W-1:0] POS_SAT  = 5'd19;

    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'd48;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;
    localparam logic [CHAR_W-1:0] UPPER_OFS  = 8'd55;
    localparam logic [CHAR_W-1:0] LOWER_OFS  = 8'd61;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_BAD_CHAR = 2'd2,
        ST_SUFFIX   = 2'd3
    } t_status;

    // Check alphabet: A-Z then 0-5
    function automatic logic [ASCII_W-1:0] check_char(input logic [GRP_LEN-1:0] mask);
        logic [ASCII_W-1:0] res;
        if (mask < 5'd26) begin
            res = 7'd65 + {2'b00, mask};
        end else begin
            res = 7'd48 + {2'b00, mask - 5'd26};
        end
        return res;
    endfunction

endpackage

>>> design/base62_id_parse_case_check.sv
// Parses a base-62 record ID streamed one ASCII character per request (tlast on the
// final character) and returns one result per ID: three 30-bit words holding the
// 6-bit values of characters 0-4, 5-9 and 10-14 (first character of a group in the
// top bits), the three case check characters, and a status (0 ok, 1 bad length,
// 2 invalid character, 3 suffix mismatch, first match wins). One character is
// taken every cycle. The only stall is a last character that waits in the input
// register while the previous result is still held on the output. A character goes
// through an input register and one stage of decode/shift logic, and a result is
// registered on the output when its last character leaves the input register.
// Output tdata from bit 0: prefix_word, high_word, low_word, check_char_0,
// check_char_1, check_char_2, status, zero fill to 120 bits.
module base62_id_parse_case_check
    import b62_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,   // char_code
    input  logic             s_axis_tlast,    // last
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // prefix_word[29:0], high_word[59:30], low_word[89:60], check_char_0[96:90],
    // check_char_1[103:97], check_char_2[110:104], status[112:111], zeros above
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic                r_in_valid;
    logic [CHAR_W-1:0]   r_in_char;
    logic                r_in_last;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic [POS_W-1:0]    r_pos;
    logic [WORD_W-1:0]   r_words [GROUPS];
    logic [MASK_W-1:0]   r_masks;
    logic                r_bad;
    logic                r_mismatch;

    logic [POS_W-1:0]    n_pos;
    logic [WORD_W-1:0]   n_words [GROUPS];
    logic [MASK_W-1:0]   n_masks;
    logic                n_bad;
    logic                n_mismatch;
    logic [OUT_W-1:0]    n_out_data;

    logic                advance;
    logic                in_take;
    logic                out_take;
    logic [VAL_W-1:0]    char_val;
    logic                char_upper;
    logic                char_ok;
    logic [1:0]          grp;
    logic [ASCII_W-1:0]  sfx_check;
    logic [ASCII_W-1:0]  chk [GROUPS];
    t_status             status;

    assign out_take      = r_out_valid && m_axis_tready;
    // an item without last never needs the output register
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // character decode
    always_comb begin
        char_val   = '0;
        char_upper = 1'b0;
        char_ok    = 1'b1;
        if (r_in_char >= CH_DIGIT_0 && r_in_char <= CH_DIGIT_9) begin
            char_val = VAL_W'(r_in_char - CH_DIGIT_0);
        end else if (r_in_char >= CH_UPPER_A && r_in_char <= CH_UPPER_Z) begin
            char_val   = VAL_W'(r_in_char - UPPER_OFS);
            char_upper = 1'b1;
        end else if (r_in_char >= CH_LOWER_A && r_in_char <= CH_LOWER_Z) begin
            char_val = VAL_W'(r_in_char - LOWER_OFS);
        end else begin
            char_ok = 1'b0;
        end
    end

    always_comb begin
        if (r_pos >= 5'd10) begin
            grp = 2'd2;
        end else if (r_pos >= 5'd5) begin
            grp = 2'd1;
        end else begin
            grp = 2'd0;
        end
    end

    // suffix character compares against the check of its own group
    always_comb begin
        case (r_pos)
            5'd15:   sfx_check = check_char(r_masks[4:0]);
            5'd16:   sfx_check = check_char(r_masks[9:5]);
            default: sfx_check = check_char(r_masks[14:10]);
        endcase
    end

    always_comb begin
        n_words    = r_words;
        n_masks    = r_masks;
        n_bad      = r_bad;
        n_mismatch = r_mismatch;
        if (r_pos < BODY_LEN) begin
            for (int g = 0; g < GROUPS; g++) begin
                if (grp == 2'(g)) begin
                    n_words[g] = {r_words[g][WORD_W-VAL_W-1:0], char_val};
                end
            end
            // within the body, the mask bit index equals the position
            if (char_upper) begin
                n_masks[r_pos[3:0]] = 1'b1;
            end
            if (!char_ok) begin
                n_bad = 1'b1;
            end
        end else if (r_pos < FULL_LEN) begin
            if (r_in_char != {1'b0, sfx_check}) begin
                n_mismatch = 1'b1;
            end
        end
        n_pos = (r_pos < POS_SAT) ? r_pos + 5'd1 : r_pos;
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            chk[g] = check_char(n_masks[g*GRP_LEN +: GRP_LEN]);
        end
        if (n_pos != BODY_LEN && n_pos != FULL_LEN) begin
            status = ST_BAD_LEN;
        end else if (n_bad) begin
            status = ST_BAD_CHAR;
        end else if (n_pos == FULL_LEN && n_mismatch) begin
            status = ST_SUFFIX;
        end else begin
            status = ST_OK;
        end
        n_out_data = {7'd0, status, chk[2], chk[1], chk[0],
                      n_words[2], n_words[1], n_words[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_masks     <= '0;
            r_bad       <= 1'b0;
            r_mismatch  <= 1'b0;
            for (int g = 0; g < GROUPS; g++) begin
                r_words[g] <= '0;
            end
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                if (r_in_last) begin
                    // drop all state, ready for the next ID
                    r_pos      <= '0;
                    r_masks    <= '0;
                    r_bad      <= 1'b0;
                    r_mismatch <= 1'b0;
                    for (int g = 0; g < GROUPS; g++) begin
                        r_words[g] <= '0;
                    end
                end else begin
                    r_pos      <= n_pos;
                    r_masks    <= n_masks;
                    r_bad      <= n_bad;
                    r_mismatch <= n_mismatch;
                    r_words    <= n_words;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance && r_in_last) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
